### rtl/totq_pkg.sv
package totq_pkg;

	localparam int CAPACITY    = 64;
	localparam int HANDLE_BITS = 16;
	localparam int TIME_BITS   = 48;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;

	localparam int IN_BITS  = HANDLE_BITS + 2 * TIME_BITS + 3;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = HANDLE_BITS + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_DEL  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REPLACED = 3'd1;
	localparam logic [2:0] ST_KEPT     = 3'd2;
	localparam logic [2:0] ST_ASLEEP   = 3'd3;
	localparam logic [2:0] ST_REMOVED  = 3'd4;
	localparam logic [2:0] ST_NOTFOUND = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;
	localparam logic [2:0] ST_EXPIRED  = 3'd7;

	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [TIME_BITS-1:0]   time_t;

	typedef struct packed {
		handle_t handle;
		time_t   expiry;
	} slot_t;

endpackage

### rtl/timeout_ordered_timer_queue.sv
// Timer queue: holds up to CAPACITY object handles ordered by expiry time,
// equal expiries kept in order of arrival.
// Requests arrive on the s_ channel: s_tuser carries the operation (add,
// delete, tick) and s_tdata the handle, times and flags. Results leave on the
// m_ channel: m_tuser is the status, m_tdata the expired handle and its flag,
// and m_tlast marks the final result of a request.
// The table lives in a single-port-read, single-port-write memory with a
// registered read, driven by a small sequencer around one time comparator.
// Every table element visited takes an address step, then a use step. An
// add (unless refused for a sleeping owner) or delete scans for the handle,
// a removal shifts the tail down and an insert scans for its place and
// shifts the tail up. A tick scans the due entries (one result each) and
// then shifts the rest down.
// Only one request is in work at a time; s_tready is high while idle.
// Reset empties the table at once (the fill count is cleared); no sweep runs.
// A result waits in the output register while the receiver stalls; the
// sequencer holds at the step that produces the next result until the
// register frees up, and a new request may be taken while the last result of
// the previous one still waits.
module timeout_ordered_timer_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// object_handle, timeout, current_time, overwrite, ignore_sleep, owner_asleep
	input  logic [totq_pkg::IN_W-1:0]  s_tdata,
	// operation
	input  logic [1:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// expired_handle, has_handle
	output logic [totq_pkg::OUT_W-1:0] m_tdata,
	// status
	output logic [2:0]               m_tuser,
	output logic                     m_tlast
);
	import totq_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SRCH  = 4'd1;
	localparam logic [3:0] S_SUSE  = 4'd2;
	localparam logic [3:0] S_SHL   = 4'd3;
	localparam logic [3:0] S_SHLW  = 4'd4;
	localparam logic [3:0] S_ISCAN = 4'd5;
	localparam logic [3:0] S_IUSE  = 4'd6;
	localparam logic [3:0] S_SHR   = 4'd7;
	localparam logic [3:0] S_SHRW  = 4'd8;
	localparam logic [3:0] S_TSCAN = 4'd9;
	localparam logic [3:0] S_TUSE  = 4'd10;
	localparam logic [3:0] S_TEND  = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;

	slot_t mem [CAPACITY];
	slot_t rd_q;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q, idx_q, gap_q, pos_q;
	logic [1:0]    op_q;
	handle_t       h_q, pend_h_q, eh_q;
	time_t         t_q, now_q;
	logic          ovw_q, pend_q, has_q;
	logic [2:0]    st_q;

	logic          out_v_q, out_last_q, out_has_q;
	logic [2:0]    out_st_q;
	handle_t       out_h_q;

	// Request fields.
	handle_t in_h;
	time_t   in_t, in_now;
	logic    in_ovw, in_ign, in_asl;
	assign in_h   = s_tdata[HANDLE_BITS-1:0];
	assign in_t   = s_tdata[HANDLE_BITS +: TIME_BITS];
	assign in_now = s_tdata[HANDLE_BITS+TIME_BITS +: TIME_BITS];
	assign in_ovw = s_tdata[HANDLE_BITS+2*TIME_BITS];
	assign in_ign = s_tdata[HANDLE_BITS+2*TIME_BITS+1];
	assign in_asl = s_tdata[HANDLE_BITS+2*TIME_BITS+2];

	logic [CW:0] src_sum;
	assign src_sum = {1'b0, idx_q} + {1'b0, gap_q};

	logic can_emit;
	assign can_emit = !out_v_q || m_tready;

	// The one shared comparator: insert place (t < expiry) or due (expiry < now).
	time_t cmp_a, cmp_b;
	logic  cmp_lt;
	assign cmp_a  = (state_q == S_IUSE) ? t_q : rd_q.expiry;
	assign cmp_b  = (state_q == S_IUSE) ? rd_q.expiry : now_q;
	assign cmp_lt = cmp_a < cmp_b;

	// The output register takes a new result at the final step of a request,
	// or during a tick scan when a further due entry proves the held one is
	// not the last.
	logic out_load;
	assign out_load = can_emit &&
		((state_q == S_EMIT) || (state_q == S_TUSE && cmp_lt && pend_q));

	logic [AW-1:0] rd_addr;
	always_comb begin
		unique case (state_q)
			S_SHL, S_SHLW: rd_addr = src_sum[AW-1:0];
			S_SHR, S_SHRW: rd_addr = idx_q[AW-1:0] - AW'(1);
			default:       rd_addr = idx_q[AW-1:0];
		endcase
	end

	logic          we;
	logic [AW-1:0] wa;
	slot_t         wd;
	always_comb begin
		we = 1'b0;
		wa = idx_q[AW-1:0];
		wd = rd_q;
		if (state_q == S_SHLW || state_q == S_SHRW) begin
			we = 1'b1;
		end else if (state_q == S_SHR && idx_q == pos_q) begin
			we = 1'b1;
			wd = '{handle: h_q, expiry: t_q};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (we) begin
			mem[wa] <= wd;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			gap_q   <= '0;
			pos_q   <= '0;
			pend_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q   <= s_tuser;
						h_q    <= in_h;
						t_q    <= in_t;
						now_q  <= in_now;
						ovw_q  <= in_ovw;
						idx_q  <= '0;
						pend_q <= 1'b0;
						eh_q   <= '0;
						has_q  <= 1'b0;
						if (s_tuser == OP_ADD && in_asl && !in_ign) begin
							st_q    <= ST_ASLEEP;
							state_q <= S_EMIT;
						end else if (s_tuser == OP_ADD || s_tuser == OP_DEL) begin
							state_q <= S_SRCH;
						end else if (s_tuser == OP_TICK) begin
							state_q <= S_TSCAN;
						end
					end
				end
				S_SRCH: begin
					if (idx_q == count_q) begin
						if (op_q == OP_DEL) begin
							st_q    <= ST_NOTFOUND;
							state_q <= S_EMIT;
						end else if (count_q == CW'(CAPACITY)) begin
							st_q    <= ST_FULL;
							state_q <= S_EMIT;
						end else begin
							st_q    <= ST_INSERTED;
							idx_q   <= '0;
							state_q <= S_ISCAN;
						end
					end else begin
						state_q <= S_SUSE;
					end
				end
				S_SUSE: begin
					if (rd_q.handle == h_q) begin
						gap_q <= CW'(1);
						if (op_q == OP_DEL) begin
							st_q    <= ST_REMOVED;
							state_q <= S_SHL;
						end else if (!ovw_q) begin
							st_q    <= ST_KEPT;
							state_q <= S_EMIT;
						end else begin
							st_q    <= ST_REPLACED;
							state_q <= S_SHL;
						end
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SRCH;
					end
				end
				S_SHL: begin
					if (src_sum >= {1'b0, count_q}) begin
						count_q <= count_q - gap_q;
						idx_q   <= '0;
						state_q <= (op_q == OP_ADD) ? S_ISCAN : S_EMIT;
					end else begin
						state_q <= S_SHLW;
					end
				end
				S_SHLW: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_SHL;
				end
				S_ISCAN: begin
					if (idx_q == count_q) begin
						pos_q   <= idx_q;
						state_q <= S_SHR;
					end else begin
						state_q <= S_IUSE;
					end
				end
				S_IUSE: begin
					if (cmp_lt) begin
						pos_q   <= idx_q;
						idx_q   <= count_q;
						state_q <= S_SHR;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_ISCAN;
					end
				end
				S_SHR: begin
					if (idx_q == pos_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SHRW;
					end
				end
				S_SHRW: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SHR;
				end
				S_TSCAN: begin
					state_q <= (idx_q == count_q) ? S_TEND : S_TUSE;
				end
				S_TUSE: begin
					if (!cmp_lt) begin
						state_q <= S_TEND;
					end else if (!pend_q || can_emit) begin
						// The earlier due entry is not the last one.
						if (pend_q) begin
							out_st_q   <= ST_EXPIRED;
							out_h_q    <= pend_h_q;
							out_has_q  <= 1'b1;
							out_last_q <= 1'b0;
						end
						pend_q   <= 1'b1;
						pend_h_q <= rd_q.handle;
						idx_q    <= idx_q + CW'(1);
						state_q  <= S_TSCAN;
					end
				end
				S_TEND: begin
					st_q  <= ST_EXPIRED;
					eh_q  <= pend_q ? pend_h_q : '0;
					has_q <= pend_q;
					gap_q <= idx_q;
					idx_q <= '0;
					state_q <= (idx_q != '0) ? S_SHL : S_EMIT;
				end
				S_EMIT: begin
					if (can_emit) begin
						out_st_q   <= st_q;
						out_h_q    <= eh_q;
						out_has_q  <= has_q;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_W'({out_has_q, out_h_q});

	// The fill count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// An upward shift only runs with room for one more entry.
	a_shr_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHR) |-> (count_q < CW'(CAPACITY)))
		else $error("insert into a full table");

	// A tick always leaves idle for the scan.
	a_tick_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_TICK) |=> (state_q == S_TSCAN))
		else $error("tick did not start its scan");

	// A removal shift never drops more entries than are stored.
	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHL) |-> (gap_q <= count_q))
		else $error("shift gap exceeds count");

endmodule

### bench/tb_top.sv
module tb_top;
	import totq_pkg::*;

	// Operation code 3 is unused: the block swallows it without a result.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

	// One request as the sender sees it, plus an optional hand-typed status.
	typedef struct {
		logic [1:0] op;
		handle_t    handle;
		time_t      timeout;
		time_t      now;
		bit         overwrite;
		bit         ignore_sleep;
		bit         asleep;
		bit         typed;
		logic [2:0] typed_status;
	} request_t;

	// One result word: status, popped handle, its flag and the last marker.
	typedef struct {
		logic [2:0] status;
		handle_t    handle;
		bit         has_handle;
		bit         last;
	} outcome_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;   // handle, timeout, current_time, overwrite, ignore_sleep, asleep
	logic [1:0]          s_tuser;   // operation
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;   // expired_handle, has_handle
	logic [2:0]          m_tuser;   // status
	logic                m_tlast;

	timeout_ordered_timer_queue dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Shadow copy of the timer table, kept in queue order.
	handle_t  shadow_handle[$];
	time_t    shadow_expiry[$];
	outcome_t pending_results[$];

	int     failures;
	int     tx_idle_pct;
	int     rx_idle_pct;
	int     rx_hold_cycles;
	time_t  wall_ms;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Safety net against a hung handshake.
	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void push_result(logic [2:0] st, handle_t h, bit has, bit last);
		outcome_t o;
		o.status = st;
		o.handle = h;
		o.has_handle = has;
		o.last = last;
		pending_results.push_back(o);
	endfunction

	function automatic int find_handle(handle_t h);
		for (int i = 0; i < shadow_handle.size(); i++)
			if (shadow_handle[i] == h)
				return i;
		return -1;
	endfunction

	// New entries go behind every entry whose expiry is not later than theirs.
	function automatic void insert_by_expiry(handle_t h, time_t t);
		int pos;
		pos = 0;
		while (pos < shadow_expiry.size() && shadow_expiry[pos] <= t)
			pos++;
		shadow_handle.insert(pos, h);
		shadow_expiry.insert(pos, t);
	endfunction

	// Applies one accepted request to the shadow table and queues what the
	// block must answer. Hand-typed rows replace the computed single result.
	function automatic void predict_timer_queue(request_t r);
		int pos;
		int due;
		int before_cnt;
		before_cnt = pending_results.size();
		case (r.op)
			OP_ADD: begin
				pos = find_handle(r.handle);
				if (r.asleep && !r.ignore_sleep) begin
					push_result(ST_ASLEEP, '0, 0, 1);
				end else if (pos >= 0) begin
					if (!r.overwrite) begin
						push_result(ST_KEPT, '0, 0, 1);
					end else begin
						shadow_handle.delete(pos);
						shadow_expiry.delete(pos);
						insert_by_expiry(r.handle, r.timeout);
						push_result(ST_REPLACED, '0, 0, 1);
					end
				end else if (shadow_handle.size() >= CAPACITY) begin
					push_result(ST_FULL, '0, 0, 1);
				end else begin
					insert_by_expiry(r.handle, r.timeout);
					push_result(ST_INSERTED, '0, 0, 1);
				end
			end
			OP_DEL: begin
				pos = find_handle(r.handle);
				if (pos < 0) begin
					push_result(ST_NOTFOUND, '0, 0, 1);
				end else begin
					shadow_handle.delete(pos);
					shadow_expiry.delete(pos);
					push_result(ST_REMOVED, '0, 0, 1);
				end
			end
			OP_TICK: begin
				due = 0;
				while (due < shadow_expiry.size() && shadow_expiry[due] < r.now)
					due++;
				if (due == 0)
					push_result(ST_EXPIRED, '0, 0, 1);
				for (int i = 0; i < due; i++)
					push_result(ST_EXPIRED, shadow_handle[i], 1, i == due - 1);
				for (int i = 0; i < due; i++) begin
					void'(shadow_handle.pop_front());
					void'(shadow_expiry.pop_front());
				end
			end
			default: ;
		endcase
		if (r.typed) begin
			void'(pending_results.pop_back());
			push_result(r.typed_status, '0, 0, 1);
		end
	endfunction

	// Drives one request from the falling edge and holds it until the block
	// takes it. The shadow table moves at the accepting edge.
	task automatic send_request(request_t r);
		logic [IN_W-1:0] word;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		word = '0;
		word[IN_BITS-1:0] = {r.asleep, r.ignore_sleep, r.overwrite, r.now, r.timeout, r.handle};
		s_tdata = word;
		s_tuser = r.op;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_timer_queue(r);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain_results();
		go_quiet();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic time_t random_time();
		return time_t'({$urandom, $urandom});
	endfunction

	// Mostly a small pool of handles around a slowly advancing clock, so that
	// replaces, keeps, ties and partial pops are common; a few wild values.
	function automatic request_t random_request();
		request_t r;
		int pick;
		pick = $urandom_range(99);
		r.op = pick < 50 ? OP_ADD : pick < 70 ? OP_DEL : pick < 96 ? OP_TICK : OP_UNUSED;
		r.handle = $urandom_range(99) < 85 ? handle_t'($urandom_range(11)) : handle_t'($urandom);
		if ($urandom_range(99) < 8) begin
			r.timeout = random_time();
			r.now = random_time();
		end else begin
			if (r.op == OP_TICK)
				wall_ms += $urandom_range(12);
			r.timeout = wall_ms + $urandom_range(40);
			r.now = wall_ms;
		end
		r.overwrite = $urandom_range(99) < 70;
		r.ignore_sleep = 1'($urandom_range(1));
		r.asleep = $urandom_range(99) < 20;
		r.typed = 0;
		r.typed_status = ST_INSERTED;
		return r;
	endfunction

	function automatic request_t make_request(logic [1:0] op, handle_t h, time_t tmo, time_t now,
			bit ovw, bit ign, bit slp);
		request_t r;
		r = '{op, h, tmo, now, ovw, ign, slp, 0, ST_INSERTED};
		return r;
	endfunction

	// Result checker: the oldest expectation must match every field.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request waiting: status %0d handle %0h", m_tuser,
					m_tdata[HANDLE_BITS-1:0]);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					failures++;
				end
				if (m_tdata[HANDLE_BITS-1:0] !== want.handle) begin
					$error("expired_handle: expected %0h, got %0h", want.handle,
						m_tdata[HANDLE_BITS-1:0]);
					failures++;
				end
				if (m_tdata[HANDLE_BITS] !== want.has_handle) begin
					$error("has_handle: expected %0d, got %0d", want.has_handle,
						m_tdata[HANDLE_BITS]);
					failures++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					failures++;
				end
			end
		end
	end

	// Receiver: random back-pressure, or a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			m_tready = 1'b0;
			rx_hold_cycles--;
		end else begin
			m_tready = $urandom_range(99) >= rx_idle_pct;
		end
	end

	initial begin
		request_t directed[$];
		request_t r;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_TICK;
		m_tready = 1'b0;
		failures = 0;
		rx_hold_cycles = 0;
		wall_ms = 1000;
		tx_idle_pct = 25;
		rx_idle_pct = 57;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed table. Rows whose answer is obvious carry it typed in.
		r = make_request(OP_TICK, 0, 0, 0, 0, 0, 0);
		r.typed = 1; r.typed_status = ST_EXPIRED;                 // empty table, nothing due
		directed.push_back(r);
		r = make_request(OP_DEL, 5, 0, 0, 0, 0, 0);
		r.typed = 1; r.typed_status = ST_NOTFOUND;                // absent handle
		directed.push_back(r);
		r = make_request(OP_ADD, 1, 100, 0, 1, 0, 1);
		r.typed = 1; r.typed_status = ST_ASLEEP;                  // sleeping owner refused
		directed.push_back(r);
		directed.push_back(make_request(OP_ADD, 1, 100, 0, 1, 1, 1));      // sleep ignored
		directed.push_back(make_request(OP_ADD, 2, 100, 0, 0, 0, 0));      // equal expiry
		directed.push_back(make_request(OP_ADD, 3, 50, 0, 1, 0, 0));
		directed.push_back(make_request(OP_ADD, 0, 0, TIME_MAX, 1, 0, 0));
		directed.push_back(make_request(OP_ADD, 16'hFFFF, TIME_MAX, 0, 1, 1, 0));
		directed.push_back(make_request(OP_ADD, 2, 10, 0, 0, 0, 0));       // present, kept
		directed.push_back(make_request(OP_ADD, 2, 10, 0, 1, 0, 0));       // present, moved
		r = make_request(OP_ADD, 3, 7, 0, 1, 0, 1);
		r.typed = 1; r.typed_status = ST_ASLEEP;                  // refused even when present
		directed.push_back(r);
		r = make_request(OP_DEL, 3, 0, 0, 0, 0, 0);
		r.typed = 1; r.typed_status = ST_REMOVED;
		directed.push_back(r);
		directed.push_back(make_request(OP_UNUSED, 16'hFFFF, TIME_MAX, TIME_MAX, 1, 1, 1));
		directed.push_back(make_request(OP_TICK, 0, 0, 100, 0, 0, 0));     // pops two
		directed.push_back(make_request(OP_TICK, 0, 0, 101, 0, 0, 0));
		directed.push_back(make_request(OP_TICK, 0, 0, TIME_MAX, 0, 0, 0)); // max never due
		r = make_request(OP_DEL, 16'hFFFF, 0, 0, 0, 0, 0);
		r.typed = 1; r.typed_status = ST_REMOVED;
		directed.push_back(r);
		r = make_request(OP_TICK, 0, 0, TIME_MAX, 0, 0, 0);
		r.typed = 1; r.typed_status = ST_EXPIRED;                 // table empty again
		directed.push_back(r);
		foreach (directed[i])
			send_request(directed[i]);

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = phase == 0 ? 25 : phase == 1 ? 57 : 0;
			rx_idle_pct = phase == 0 ? 57 : phase == 1 ? 25 : 0;
			// The sender waits out every outstanding result between phases.
			drain_results();

			if (phase == 1) begin
				// Fill the table past capacity, then pop everything at once.
				for (int i = 0; i < CAPACITY + 4; i++)
					send_request(make_request(OP_ADD, handle_t'(16'h4000 + i),
						time_t'($urandom_range(30)), 0, 1, 1, 0));
				send_request(make_request(OP_ADD, 16'h4001, 5, 0, 1, 0, 0));
				send_request(make_request(OP_TICK, 0, 0, TIME_MAX, 0, 0, 0));
			end
			if (phase == 2) begin
				// Receiver holds off while requests keep coming, so input stalls.
				rx_hold_cycles = 400;
				for (int i = 0; i < 12; i++)
					send_request(random_request());
			end
			for (int i = 0; i < 124; i++)
				send_request(random_request());
		end

		drain_results();
		repeat (1000) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### timeout_ordered_timer_queue.f
rtl/totq_pkg.sv
rtl/timeout_ordered_timer_queue.sv
bench/tb_top.sv
